// ----- design/svs_pkg.sv -----
// Shared types for the set victim selector: policy codes, opcodes and the
// controller/datapath command and status structs. No dependencies.
package svs_pkg;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_TOUCH  = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;

    typedef enum logic [1:0]
    {
        POL_LRU,
        POL_MRU,
        POL_RR,
        POL_RAND
    } policy_t;

    typedef enum logic [1:0]
    {
        SRC_NONE,
        SRC_FFI,
        SRC_BEST,
        SRC_SEEK
    } res_src_t;

    typedef enum logic [1:0]
    {
        FROM_PTR,
        FROM_PTR_NEXT,
        FROM_MOD
    } seek_from_t;

    typedef struct packed
    {
        logic       flag_we;
        logic       ts_we;
        logic       scan_clear;
        logic       scan_issue;
        logic       mod_init;
        logic       mod_step;
        logic       seek_init;
        seek_from_t seek_from;
        logic       seek_step;
        logic       rr_update;
        logic       load_result;
        res_src_t   src;
        policy_t    policy;
    } cmd_t;

    typedef struct packed
    {
        logic addr_last;
        logic ffi_found;
        logic any_free;
        logic seek_hit;
    } status_t;

endpackage

// ----- design/set_victim_selector_unit.sv -----
// Top level of the set victim selector: stream ports, config channel,
// controller and datapath. Depends on svs_pkg, svs_ctrl, svs_datapath.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  item: tuser opcode, tdata way/flags/time
//  m_*       out        m_tvalid / m_tready  result: tuser found, tdata way/valid
//  cfg_*     in         cfg_valid/cfg_ready  policy_mode
//
// Set, touch and unused opcodes give no result beat.
// A select scans the single-ported last-use memory sequentially; round robin
// then seeks a free way from its pointer, and random first takes a reciprocal
// remainder of the LFSR and seeks a free way from there.
// Reset is asynchronous, active low; no clearing pass is needed.
// s_tready is high only while idle; a waiting result beat holds only the
// final load of the next select, and cfg_ready is always high.
module set_victim_selector_unit #(
    parameter int WAYS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // way[2:0], valid_in[3], busy_in[4], timestamp[36:5]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // victim_way[2:0], victim_was_valid[3]
    output logic [0:0]  m_tuser,   // found[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);
    import svs_pkg::*;

    cmd_t       cmd;
    status_t    status;
    logic       found;
    logic [2:0] victim_way;
    logic       victim_was_valid;

    assign cfg_ready = 1'b1;

    svs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .opcode    (s_tuser),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    svs_datapath #(
        .WAYS (WAYS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .way              (s_tdata[2:0]),
        .valid_in         (s_tdata[3]),
        .busy_in          (s_tdata[4]),
        .timestamp        (s_tdata[36:5]),
        .status           (status),
        .found            (found),
        .victim_way       (victim_way),
        .victim_was_valid (victim_was_valid)
    );

    assign m_tdata = {4'd0, victim_was_valid, victim_way};
    assign m_tuser = found;

endmodule

// ----- design/svs_datapath.sv -----
// Datapath of the set victim selector: way flags, last-use memory, scan
// registers, LFSR, remainder unit, seek pointer and result register.
// Depends on svs_pkg.
module svs_datapath #(
    parameter int WAYS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  svs_pkg::cmd_t   cmd,
    input  logic [2:0]      way,
    input  logic            valid_in,
    input  logic            busy_in,
    input  logic [31:0]     timestamp,
    output svs_pkg::status_t status,
    output logic            found,
    output logic [2:0]      victim_way,
    output logic            victim_was_valid
);
    import svs_pkg::*;

    localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KW = $clog2(WAYS);
    localparam int SHIFT = 16 + KW;
    localparam logic [16:0] RECIP = 17'(((1 << SHIFT) + WAYS - 1) / WAYS);
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [IW-1:0] LAST_WAY = IW'(WAYS - 1);

    function automatic logic [IW-1:0] way_inc(input logic [IW-1:0] w);
        way_inc = (w == LAST_WAY) ? '0 : w + 1'b1;
    endfunction

    logic [WAYS-1:0] valid_reg;
    logic [WAYS-1:0] busy_reg;
    logic [WAYS-1:0] ts_wr_reg;
    logic [31:0]     ts_mem [WAYS];
    logic [31:0]     q_reg;
    logic            q_wr_reg;
    logic [IW-1:0]   addr_reg;
    logic [IW-1:0]   e_idx_reg;
    logic            e_vld_reg;
    logic            ffi_found_reg;
    logic [IW-1:0]   ffi_idx_reg;
    logic            any_free_reg;
    logic            have_reg;
    logic [31:0]     best_reg;
    logic [IW-1:0]   best_idx_reg;
    logic [IW-1:0]   rr_ptr_reg;
    logic [15:0]     lfsr_reg;
    logic [15:0]     quo_reg;
    logic [IW-1:0]   mod_rem_reg;
    logic [IW-1:0]   seek_w_reg;
    logic            res_found_reg;
    logic [2:0]      res_way_reg;
    logic            res_valid_reg;

    logic            way_ok;
    logic [IW-1:0]   widx;
    logic            e_free;
    logic            e_inv;
    logic [31:0]     e_time;
    logic            e_gt;
    logic            e_take;
    logic [15:0]     lfsr_next;
    logic [32:0]     mod_prod;
    logic [22:0]     mod_rem_full;
    logic [IW-1:0]   seek_start;
    logic [IW-1:0]   res_idx;

    assign way_ok = (int'(way) < WAYS);
    assign widx   = IW'(way);

    assign e_free = !busy_reg[e_idx_reg];
    assign e_inv  = !valid_reg[e_idx_reg];
    assign e_time = q_wr_reg ? q_reg : 32'd0;
    assign e_gt   = e_time > best_reg;
    assign e_take = !have_reg || ((cmd.policy == POL_MRU) ? e_gt : !e_gt);

    assign lfsr_next = lfsr_reg[0] ? ({1'b0, lfsr_reg[15:1]} ^ LFSR_TAPS)
                                   : {1'b0, lfsr_reg[15:1]};

    // LFSR mod WAYS: reciprocal multiply for the quotient, then remainder
    assign mod_prod     = 33'(lfsr_reg) * 33'(RECIP);
    assign mod_rem_full = 23'(lfsr_reg) - 23'(quo_reg) * 23'(WAYS);

    always_comb
    begin
        unique case (cmd.seek_from)
            FROM_PTR:      seek_start = rr_ptr_reg;
            FROM_PTR_NEXT: seek_start = way_inc(rr_ptr_reg);
            FROM_MOD:      seek_start = mod_rem_reg;
            default:       seek_start = rr_ptr_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.src)
            SRC_FFI:  res_idx = ffi_idx_reg;
            SRC_BEST: res_idx = best_idx_reg;
            SRC_SEEK: res_idx = seek_w_reg;
            default:  res_idx = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ts_we && way_ok)
        begin
            ts_mem[widx] <= timestamp;
        end
        if (cmd.scan_issue)
        begin
            q_reg <= ts_mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            busy_reg      <= '0;
            ts_wr_reg     <= '0;
            q_wr_reg      <= 1'b0;
            addr_reg      <= '0;
            e_idx_reg     <= '0;
            e_vld_reg     <= 1'b0;
            ffi_found_reg <= 1'b0;
            ffi_idx_reg   <= '0;
            any_free_reg  <= 1'b0;
            have_reg      <= 1'b0;
            best_reg      <= '0;
            best_idx_reg  <= '0;
            rr_ptr_reg    <= '0;
            lfsr_reg      <= 16'd1;
            quo_reg       <= '0;
            mod_rem_reg   <= '0;
            seek_w_reg    <= '0;
        end
        else
        begin
            if (cmd.flag_we && way_ok)
            begin
                valid_reg[widx] <= valid_in;
                busy_reg[widx]  <= busy_in;
            end
            if (cmd.ts_we && way_ok)
            begin
                ts_wr_reg[widx] <= 1'b1;
            end

            e_vld_reg <= cmd.scan_issue;
            if (cmd.scan_issue)
            begin
                q_wr_reg  <= ts_wr_reg[addr_reg];
                e_idx_reg <= addr_reg;
                addr_reg  <= way_inc(addr_reg);
            end

            if (cmd.scan_clear)
            begin
                addr_reg      <= '0;
                ffi_found_reg <= 1'b0;
                any_free_reg  <= 1'b0;
                have_reg      <= 1'b0;
            end
            else if (e_vld_reg && e_free)
            begin
                any_free_reg <= 1'b1;
                if (e_inv && !ffi_found_reg)
                begin
                    ffi_found_reg <= 1'b1;
                    ffi_idx_reg   <= e_idx_reg;
                end
                if (!e_inv && !ffi_found_reg && cmd.policy == POL_RAND)
                begin
                    lfsr_reg <= lfsr_next;
                end
                if (e_take)
                begin
                    have_reg     <= 1'b1;
                    best_reg     <= e_time;
                    best_idx_reg <= e_idx_reg;
                end
            end

            if (cmd.mod_init)
            begin
                quo_reg <= 16'(mod_prod >> SHIFT);
            end
            if (cmd.mod_step)
            begin
                mod_rem_reg <= mod_rem_full[IW-1:0];
            end

            if (cmd.seek_init)
            begin
                seek_w_reg <= seek_start;
            end
            else if (cmd.seek_step && busy_reg[seek_w_reg])
            begin
                seek_w_reg <= way_inc(seek_w_reg);
            end

            if (cmd.rr_update)
            begin
                rr_ptr_reg <= seek_w_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            res_found_reg <= (cmd.src != SRC_NONE);
            res_way_reg   <= 3'(res_idx);
            res_valid_reg <= (cmd.src != SRC_NONE) && valid_reg[res_idx];
        end
    end

    assign status.addr_last = (addr_reg == LAST_WAY);
    assign status.ffi_found = ffi_found_reg;
    assign status.any_free  = any_free_reg;
    assign status.seek_hit  = !busy_reg[seek_w_reg];

    assign found            = res_found_reg;
    assign victim_way       = res_way_reg;
    assign victim_was_valid = res_valid_reg;

    a_clear_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_clear |=> (!ffi_found_reg && !any_free_reg && !have_reg))
        else $error("scan state not cleared at select start");

    a_seek_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_result && cmd.src == SRC_SEEK) |-> !busy_reg[seek_w_reg])
        else $error("seek result names a busy way");

endmodule

// ----- design/svs_ctrl.sv -----
// Controller of the set victim selector: sequences scan, remainder, seek and
// result beats; owns the policy register and the output valid. Uses svs_pkg.
module svs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic [1:0]        opcode,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_data,
    input  svs_pkg::status_t  status,
    output svs_pkg::cmd_t     cmd
);
    import svs_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_MOD,
        S_SETUP,
        S_SEEK,
        S_OUT
    } state_t;

    state_t   state_reg;
    res_src_t src_reg;
    policy_t  policy_reg;
    logic     out_valid_reg;
    logic     accept;
    logic     out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        cmd        = '0;
        cmd.policy = policy_reg;
        cmd.src    = src_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.flag_we    = accept && (opcode == OP_SET);
                cmd.ts_we      = accept && (opcode == OP_TOUCH);
                cmd.scan_clear = accept && (opcode == OP_SELECT);
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            S_DECIDE:
            begin
                if (policy_reg == POL_RR && status.any_free)
                begin
                    cmd.seek_init = 1'b1;
                    cmd.seek_from = status.ffi_found ? FROM_PTR_NEXT : FROM_PTR;
                end
                cmd.mod_init = (policy_reg == POL_RAND) && !status.ffi_found
                               && status.any_free;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            S_SETUP:
            begin
                cmd.seek_init = 1'b1;
                cmd.seek_from = FROM_MOD;
            end
            S_SEEK:
            begin
                cmd.seek_step = 1'b1;
                cmd.rr_update = status.seek_hit && (policy_reg == POL_RR);
            end
            S_OUT:
            begin
                cmd.load_result = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_reg       <= SRC_NONE;
            policy_reg    <= POL_LRU;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                policy_reg <= policy_t'(cfg_data);
            end

            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && opcode == OP_SELECT)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (status.addr_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    unique case (policy_reg)
                        POL_LRU, POL_MRU:
                        begin
                            src_reg   <= !status.any_free ? SRC_NONE
                                       : (status.ffi_found ? SRC_FFI : SRC_BEST);
                            state_reg <= S_OUT;
                        end
                        POL_RR:
                        begin
                            if (status.any_free)
                            begin
                                state_reg <= S_SEEK;
                            end
                            else
                            begin
                                src_reg   <= SRC_NONE;
                                state_reg <= S_OUT;
                            end
                        end
                        default:
                        begin
                            if (status.ffi_found)
                            begin
                                src_reg   <= SRC_FFI;
                                state_reg <= S_OUT;
                            end
                            else if (!status.any_free)
                            begin
                                src_reg   <= SRC_NONE;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_MOD;
                            end
                        end
                    endcase
                end
                S_MOD:
                begin
                    state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    state_reg <= S_SEEK;
                end
                S_SEEK:
                begin
                    if (status.seek_hit)
                    begin
                        src_reg   <= SRC_SEEK;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");

    a_seek_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEEK) |-> status.any_free)
        else $error("seek started with no free way");

    a_ffi_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && status.ffi_found) |-> status.any_free)
        else $error("free invalid way found but no free way recorded");

endmodule
